### sv/p1305_pkg.sv
// Poly1305 MAC: shared types, widths and constants.
// No dependencies; imported by p1305_front, p1305_core and poly1305_mac_unit.
`default_nettype none

package p1305_pkg;

    localparam int N_LIMBS = 5;
    localparam int LIMB_W  = 26;
    localparam int ACC_W   = 27;
    localparam int HS_W    = 28;
    localparam int COEF_W  = 29;
    localparam int PROD_W  = HS_W + COEF_W;
    localparam int SUM_W   = 60;
    localparam int CARRY_W = SUM_W - LIMB_W;
    localparam int BLK_W   = 129;

    localparam logic [LIMB_W-1:0] LIMB_MASK = 26'h3ffffff;
    localparam logic [LIMB_W-1:0] CLAMP_R1  = 26'h3ffff03;
    localparam logic [LIMB_W-1:0] CLAMP_R2  = 26'h3ffc0ff;
    localparam logic [LIMB_W-1:0] CLAMP_R3  = 26'h3f03fff;
    localparam logic [LIMB_W-1:0] CLAMP_R4  = 26'h00fffff;
    localparam logic [31:0]       TOP_LIMB  = 32'h0400_0000;
    localparam logic [7:0]        PAD_BYTE  = 8'h01;
    localparam logic [4:0]        FULL_CNT  = 5'd16;

    localparam logic [1:0] CFG_R_LOW  = 2'd0;
    localparam logic [1:0] CFG_R_HIGH = 2'd1;
    localparam logic [1:0] CFG_S_LOW  = 2'd2;
    localparam logic [1:0] CFG_S_HIGH = 2'd3;

    typedef struct packed {
        logic [63:0] block_low;
        logic [63:0] block_high;
        logic [4:0]  byte_count;
        logic        last_block;
    } t_in;

    typedef struct packed {
        logic [63:0] tag_low;
        logic [63:0] tag_high;
    } t_out;

    typedef struct packed {
        logic             absorb;
        logic             last;
        logic [BLK_W-1:0] blk;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_FOLD,
        ST_FIN1,
        ST_FIN2,
        ST_FIN3
    } t_core_state;

endpackage

`default_nettype wire

### sv/p1305_fifo.sv
// Poly1305 MAC: small first-word-fall-through queue of registers.
// Uses no package; width and depth come from the instantiating module.
`default_nettype none

module p1305_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wr_data,
    output logic             o_full,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rd_data,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             w_wr, w_rd;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_wr      = i_wr && !o_full;
    assign w_rd      = i_rd && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

`default_nettype wire

### sv/p1305_front.sv
// Poly1305 MAC front end: pads and classifies each message block request.
// Depends on p1305_pkg; feeds the command queue ahead of p1305_core.
`default_nettype none

module p1305_front import p1305_pkg::*; (
    input  logic i_push,
    input  logic i_full,
    input  t_in  i_item,
    output logic o_wr,
    output t_cmd o_cmd
);

    logic [4:0]   w_n;
    logic [127:0] w_msg;
    logic [127:0] w_blk;

    always_comb begin
        w_n   = (i_item.byte_count > FULL_CNT) ? FULL_CNT : i_item.byte_count;
        w_msg = {i_item.block_high, i_item.block_low};
        for (int j = 0; j < 16; j++) begin
            if (5'(j) < w_n) begin
                w_blk[8*j +: 8] = w_msg[8*j +: 8];
            end else if (5'(j) == w_n) begin
                w_blk[8*j +: 8] = PAD_BYTE;
            end else begin
                w_blk[8*j +: 8] = 8'h00;
            end
        end
        o_cmd.absorb = (w_n != 5'd0);
        o_cmd.last   = i_item.last_block;
        o_cmd.blk    = {(w_n == FULL_CNT), w_blk};
        // an empty block that is not last is taken and dropped
        o_wr = i_push && !i_full && (o_cmd.absorb || o_cmd.last);
    end

endmodule

`default_nettype wire

### sv/p1305_core.sv
// Poly1305 MAC back end: accumulate-and-multiply mod 2^130-5, final reduction and s add.
// Depends on p1305_pkg; reads the command queue and writes the tag queue.
`default_nettype none

module p1305_core import p1305_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cmd         i_cmd,
    input  logic         i_cmd_empty,
    output logic         o_cmd_pop,
    input  logic         i_res_full,
    output logic         o_res_push,
    output t_out         o_res,
    input  logic [127:0] i_key_r,
    input  logic [127:0] i_key_s
);

    t_core_state r_state, n_state;

    logic [2:0]         r_phase;
    logic               r_last;
    logic [ACC_W-1:0]   r_h    [N_LIMBS];
    logic [HS_W-1:0]    r_hs   [N_LIMBS];
    logic [LIMB_W-1:0]  r_rot_r[N_LIMBS];
    logic [COEF_W-1:0]  r_rot_f[N_LIMBS];
    logic [PROD_W-1:0]  r_prod [N_LIMBS];
    logic [CARRY_W-1:0] r_carry;
    logic [ACC_W-1:0]   r_fh   [N_LIMBS];
    logic [63:0]        r_lo, r_hi;

    logic [LIMB_W-1:0]  w_r    [N_LIMBS];
    logic [COEF_W-1:0]  w_f    [N_LIMBS];
    logic [LIMB_W-1:0]  w_m    [N_LIMBS];
    logic [COEF_W-1:0]  w_coef [N_LIMBS];
    logic [SUM_W-1:0]   w_sum;
    logic [31:0]        w_fold;
    logic [31:0]        w_a    [N_LIMBS];
    logic [31:0]        w_g    [N_LIMBS];
    logic [31:0]        w_sel  [N_LIMBS];
    logic [31:0]        w_c;
    logic [31:0]        w_w0, w_w1, w_w2, w_w3;
    logic [127:0]       w_tag;

    // clamped r, its times-five copies and the message limbs
    always_comb begin
        w_r[0] = i_key_r[25:0] & LIMB_MASK;
        w_r[1] = i_key_r[51:26] & CLAMP_R1;
        w_r[2] = i_key_r[77:52] & CLAMP_R2;
        w_r[3] = i_key_r[103:78] & CLAMP_R3;
        w_r[4] = {2'b00, i_key_r[127:104]} & CLAMP_R4;
        for (int j = 0; j < N_LIMBS; j++) begin
            w_f[j] = COEF_W'(w_r[j]) + (COEF_W'(w_r[j]) << 2);
        end
        w_m[0] = i_cmd.blk[25:0];
        w_m[1] = i_cmd.blk[51:26];
        w_m[2] = i_cmd.blk[77:52];
        w_m[3] = i_cmd.blk[103:78];
        w_m[4] = {1'b0, i_cmd.blk[128:104]};
    end

    // column select (r on and below the diagonal, 5r above it), column sum and carry fold
    always_comb begin
        for (int j = 0; j < N_LIMBS; j++) begin
            w_coef[j] = (3'(j) <= r_phase) ? COEF_W'(r_rot_r[j]) : r_rot_f[j];
        end
        w_sum = SUM_W'(r_carry);
        for (int j = 0; j < N_LIMBS; j++) begin
            w_sum = w_sum + SUM_W'(r_prod[j]);
        end
        w_fold = 32'(r_h[0]) + (r_carry[31:0] << 2) + r_carry[31:0];
    end

    // final carry pass
    always_comb begin
        for (int j = 0; j < N_LIMBS; j++) begin
            w_a[j] = 32'(r_h[j]);
        end
        w_c    = w_a[1] >> LIMB_W;
        w_a[1] = w_a[1] & 32'(LIMB_MASK);
        w_a[2] = w_a[2] + w_c;
        w_c    = w_a[2] >> LIMB_W;
        w_a[2] = w_a[2] & 32'(LIMB_MASK);
        w_a[3] = w_a[3] + w_c;
        w_c    = w_a[3] >> LIMB_W;
        w_a[3] = w_a[3] & 32'(LIMB_MASK);
        w_a[4] = w_a[4] + w_c;
        w_c    = w_a[4] >> LIMB_W;
        w_a[4] = w_a[4] & 32'(LIMB_MASK);
        w_a[0] = w_a[0] + (w_c << 2) + w_c;
        w_c    = w_a[0] >> LIMB_W;
        w_a[0] = w_a[0] & 32'(LIMB_MASK);
        w_a[1] = w_a[1] + w_c;
    end

    // h - p trial, select, repack to 128 bits and s add
    always_comb begin
        w_g[0] = 32'(r_fh[0]) + 32'd5;
        for (int j = 1; j < N_LIMBS; j++) begin
            w_g[j]   = 32'(r_fh[j]) + (w_g[j-1] >> LIMB_W);
            w_g[j-1] = w_g[j-1] & 32'(LIMB_MASK);
        end
        w_g[4] = w_g[4] - TOP_LIMB;
        for (int j = 0; j < N_LIMBS; j++) begin
            w_sel[j] = w_g[4][31] ? 32'(r_fh[j]) : w_g[j];
        end
        w_w0 = w_sel[0] | (w_sel[1] << 26);
        w_w1 = (w_sel[1] >> 6) | (w_sel[2] << 20);
        w_w2 = (w_sel[2] >> 12) | (w_sel[3] << 14);
        w_w3 = (w_sel[3] >> 18) | (w_sel[4] << 8);
        w_tag = {r_hi, r_lo} + i_key_s;
    end

    assign o_res.tag_low  = w_tag[63:0];
    assign o_res.tag_high = w_tag[127:64];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (!i_cmd_empty && (!i_cmd.last || !i_res_full)) begin
                    o_cmd_pop = 1'b1;
                    n_state   = i_cmd.absorb ? ST_MUL : ST_FIN1;
                end
            end
            ST_MUL: begin
                if (r_phase == 3'd5) begin
                    n_state = ST_FOLD;
                end
            end
            ST_FOLD: begin
                n_state = r_last ? ST_FIN1 : ST_IDLE;
            end
            ST_FIN1: begin
                n_state = ST_FIN2;
            end
            ST_FIN2: begin
                n_state = ST_FIN3;
            end
            ST_FIN3: begin
                o_res_push = 1'b1;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // accumulator and sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_last  <= 1'b0;
            for (int j = 0; j < N_LIMBS; j++) begin
                r_h[j] <= '0;
            end
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (o_cmd_pop) begin
                        r_last  <= i_cmd.last;
                        r_phase <= '0;
                    end
                end
                ST_MUL: begin
                    r_phase <= r_phase + 3'd1;
                    if (r_phase != 3'd0) begin
                        r_h[r_phase - 3'd1] <= ACC_W'(w_sum[LIMB_W-1:0]);
                    end
                end
                ST_FOLD: begin
                    r_h[0] <= ACC_W'(w_fold[LIMB_W-1:0]);
                    r_h[1] <= ACC_W'(32'(r_h[1]) + (w_fold >> LIMB_W));
                end
                ST_FIN1: begin
                    for (int j = 0; j < N_LIMBS; j++) begin
                        r_h[j] <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (o_cmd_pop) begin
                    r_carry <= '0;
                    for (int j = 0; j < N_LIMBS; j++) begin
                        r_hs[j] <= HS_W'(r_h[j]) + HS_W'(w_m[j]);
                    end
                    r_rot_r[0] <= w_r[0];
                    r_rot_f[0] <= w_f[0];
                    for (int j = 1; j < N_LIMBS; j++) begin
                        r_rot_r[j] <= w_r[N_LIMBS - j];
                        r_rot_f[j] <= w_f[N_LIMBS - j];
                    end
                end
            end
            ST_MUL: begin
                if (r_phase != 3'd5) begin
                    for (int j = 0; j < N_LIMBS; j++) begin
                        r_prod[j] <= PROD_W'(r_hs[j]) * PROD_W'(w_coef[j]);
                    end
                    r_rot_r[0] <= r_rot_r[N_LIMBS-1];
                    r_rot_f[0] <= r_rot_f[N_LIMBS-1];
                    for (int j = 1; j < N_LIMBS; j++) begin
                        r_rot_r[j] <= r_rot_r[j-1];
                        r_rot_f[j] <= r_rot_f[j-1];
                    end
                end
                if (r_phase != 3'd0) begin
                    r_carry <= w_sum[SUM_W-1:LIMB_W];
                end
            end
            ST_FIN1: begin
                for (int j = 0; j < N_LIMBS; j++) begin
                    r_fh[j] <= w_a[j][ACC_W-1:0];
                end
            end
            ST_FIN2: begin
                r_lo <= {w_w1, w_w0};
                r_hi <= {w_w3, w_w2};
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

### sv/poly1305_mac_unit.sv
// Poly1305 one-time authenticator, top level.
// Depends on p1305_pkg, p1305_front, p1305_fifo and p1305_core.
//
// Usage:
//   Key: write r (index 0, 1) and s (index 2, 3) through i_cfg_* while idle.
//   r is clamped internally.
//   Input queue: push/full carry one 16-byte block per request with its byte
//   count and last flag. A zero-count block that is not last is dropped.
//   Output queue: empty/pop hand out one 128-bit tag per last block.
// Sequence:
//   A non-empty block passes through the core as one load, five product
//   columns through five shared multipliers plus one drain, one carry fold.
//   A last block adds a carry pass, a trial subtract and the s add; an empty
//   last block goes straight from the load to these. The core takes a new
//   block only once it is through with the one before.
// Reset: clears the key registers, the accumulator and both queues.
// Stall: blocks keep being accepted while the command queue has room; a last
//   block waits in that queue until the tag queue has a free slot.
`default_nettype none

module poly1305_mac_unit import p1305_pkg::*; #(
    parameter int CMD_DEPTH = 2,
    parameter int RES_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  t_in         i_item,
    output logic        empty,
    input  logic        pop,
    output t_out        o_result,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data
);

    logic [63:0] r_cfg_r_lo, r_cfg_r_hi, r_cfg_s_lo, r_cfg_s_hi;

    logic w_cmd_wr, w_cmd_full, w_cmd_empty, w_cmd_pop;
    logic w_res_push, w_res_full;
    t_cmd w_cmd_in, w_cmd_out;
    t_out w_res_in;
    logic [$bits(t_cmd)-1:0] w_cmd_raw;
    logic [$bits(t_out)-1:0] w_res_raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_r_lo <= '0;
            r_cfg_r_hi <= '0;
            r_cfg_s_lo <= '0;
            r_cfg_s_hi <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_R_LOW:  r_cfg_r_lo <= i_cfg_data;
                CFG_R_HIGH: r_cfg_r_hi <= i_cfg_data;
                CFG_S_LOW:  r_cfg_s_lo <= i_cfg_data;
                CFG_S_HIGH: r_cfg_s_hi <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign full = w_cmd_full;

    p1305_front u_front (
        .i_push (push),
        .i_full (w_cmd_full),
        .i_item (i_item),
        .o_wr   (w_cmd_wr),
        .o_cmd  (w_cmd_in)
    );

    p1305_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_cmd_wr),
        .i_wr_data (w_cmd_in),
        .o_full    (w_cmd_full),
        .i_rd      (w_cmd_pop),
        .o_rd_data (w_cmd_raw),
        .o_empty   (w_cmd_empty)
    );

    assign w_cmd_out = t_cmd'(w_cmd_raw);

    p1305_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd_out),
        .i_cmd_empty (w_cmd_empty),
        .o_cmd_pop   (w_cmd_pop),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res       (w_res_in),
        .i_key_r     ({r_cfg_r_hi, r_cfg_r_lo}),
        .i_key_s     ({r_cfg_s_hi, r_cfg_s_lo})
    );

    p1305_fifo #(
        .WIDTH ($bits(t_out)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_res_push),
        .i_wr_data (w_res_in),
        .o_full    (w_res_full),
        .i_rd      (pop),
        .o_rd_data (w_res_raw),
        .o_empty   (empty)
    );

    assign o_result = t_out'(w_res_raw);

endmodule

`default_nettype wire
